@@ src/assert_macros.svh @@
// Assertion macros used by the projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ src/wsp_pkg.sv @@
// Package: types, constants and arithmetic helpers of the projection block.
package wsp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_WIDTH   = 14;
    localparam int ADDR_WIDTH  = 3;
    localparam int MUL_W       = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int DIV_W       = COORD_WIDTH + FRAC_BITS;

    localparam logic [1:0] OP_LOAD_VIEW = 2'd0;
    localparam logic [1:0] OP_LOAD_PROJ = 2'd1;
    localparam logic [1:0] OP_XFORM     = 2'd2;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_WIDTH-1:0] WIDTH_RST  = CFG_WIDTH'(1280);
    localparam logic [CFG_WIDTH-1:0] HEIGHT_RST = CFG_WIDTH'(720);

    localparam logic signed [MUL_W-1:0]  FX_ONE  = MUL_W'(64'd1 << FRAC_BITS);
    localparam logic signed [PROD_W-1:0] FX_HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));

    typedef struct packed {
        logic [1:0]                     opcode;
        logic [3:0]                     elem_index;
        logic signed [COORD_WIDTH-1:0]  elem_value;
        logic signed [COORD_WIDTH-1:0]  world_x;
        logic signed [COORD_WIDTH-1:0]  world_y;
        logic signed [COORD_WIDTH-1:0]  world_z;
        logic signed [COORD_WIDTH-1:0]  world_w;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0]  screen_x;
        logic signed [COORD_WIDTH-1:0]  screen_y;
        logic                           invalid;
    } t_out_item;

    // Fixed-point product rounding: floor((p + half) / 2^F).
    function automatic logic signed [PROD_W-1:0] fx_round(input logic signed [PROD_W-1:0] p);
        fx_round = (p + FX_HALF) >>> FRAC_BITS;
    endfunction

    // True when v fits a signed coordinate.
    function automatic logic in_range(input logic signed [PROD_W-1:0] v);
        in_range = (v[PROD_W-1:COORD_WIDTH-1] == '0) || (v[PROD_W-1:COORD_WIDTH-1] == '1);
    endfunction

endpackage

@@ src/world_to_screen_projection.sv @@
// Top level: world-to-screen perspective projection on one shared multiplier.
`include "assert_macros.svh"

// World-to-screen projection. Load transfers write one element of the view or
// projection matrix. A transform transfer forms VP = view*proj and [x y z 1]*VP,
// divides clip x,y by clip w and then by the point's w, and maps the result onto
// the screen set by the width and height registers. Everything runs on one 33x33
// signed multiplier and one radix-2 divider (one quotient bit per cycle) under a
// small sequencer, which steps through the 64 matrix products (read, multiply,
// accumulate), the clip vector, the four divides, the screen mapping and the
// posting of the result. A zero divisor or any out-of-range value ends the
// transform early with invalid set and zero coordinates. The input is not ready
// during a transform; a finished result waits in the output register while the
// next transfer is taken.
module world_to_screen_projection (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  wsp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output wsp_pkg::t_out_item   o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [wsp_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CW  = wsp_pkg::COORD_WIDTH;
    localparam int MW  = wsp_pkg::MUL_W;
    localparam int PW  = wsp_pkg::PROD_W;
    localparam int DW  = wsp_pkg::DIV_W;
    localparam int CNW = $clog2(DW);

    typedef enum logic [3:0] {
        S_IDLE, S_VP_RD, S_VP_MUL, S_VP_ACC, S_CL_MUL, S_CL_ACC,
        S_DV_INIT, S_DV_RUN, S_DV_DONE, S_SC_MUL, S_SC_CHK, S_OUT
    } t_state;

    t_state r_state;

    // config registers
    logic [wsp_pkg::CFG_WIDTH-1:0] r_width, r_height;

    // matrix stores, registered read
    logic signed [CW-1:0] r_view_mem [16];
    logic signed [CW-1:0] r_proj_mem [16];
    logic signed [CW-1:0] r_view_q, r_proj_q;

    // sequencer counters
    logic [3:0] r_i;      // VP element, row*4+col
    logic [1:0] r_k;      // inner-product term
    logic [1:0] r_col;    // clip column: 0, 1, 3
    logic [1:0] r_dsel;   // which divide
    logic       r_sc;     // screen axis: 0 x, 1 y
    logic [CNW-1:0] r_cnt;

    // datapath
    logic signed [CW-1:0] r_pt [4];
    logic signed [CW-1:0] r_ww;
    logic signed [CW-1:0] r_vp [16];
    logic signed [CW-1:0] r_clip_x, r_clip_y, r_clip_w;
    logic signed [CW-1:0] r_nx, r_ny, r_wx, r_wy, r_sx, r_sy;
    logic signed [PW-1:0] r_prod, r_acc;
    logic                 r_ok;

    // divider
    logic [DW-1:0]   r_dd;    // dividend shifting out, quotient shifting in
    logic [CW-1:0]   r_rem;
    logic [CW-1:0]   r_den;
    logic            r_neg;

    logic            r_out_valid;
    wsp_pkg::t_out_item r_out_data;

    // combinational
    logic                 in_acc;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] acc_sum, sc_val;
    logic                 sum_ok;
    logic signed [CW-1:0] dv_num, dv_den;
    logic [MW-1:0]        num_mag, den_mag;
    logic [CW:0]          trial;
    logic                 trial_ge;
    logic                 dv_fit;
    logic signed [CW-1:0] dv_q;

    assign in_acc = i_in_valid && o_in_ready;
    // no transfer is taken while reset is held
    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == wsp_pkg::CFG_IDX_HEIGHT)
                  ? {{(32-wsp_pkg::CFG_WIDTH){1'b0}}, r_height}
                  : {{(32-wsp_pkg::CFG_WIDTH){1'b0}}, r_width};

    // shared multiplier operand select
    always_comb begin
        mul_a = {r_view_q[CW-1], r_view_q};
        mul_b = {r_proj_q[CW-1], r_proj_q};
        case (r_state)
            S_CL_MUL: begin
                mul_a = (r_k == 2'd3) ? wsp_pkg::FX_ONE : {r_pt[r_k][CW-1], r_pt[r_k]};
                mul_b = {r_vp[{r_k, r_col}][CW-1], r_vp[{r_k, r_col}]};
            end
            S_SC_MUL: begin
                mul_a = r_sc ? (wsp_pkg::FX_ONE - {r_wy[CW-1], r_wy})
                             : ({r_wx[CW-1], r_wx} + wsp_pkg::FX_ONE);
                mul_b = $signed({{(MW-wsp_pkg::CFG_WIDTH){1'b0}}, r_sc ? r_height : r_width});
            end
            default: ;
        endcase
    end

    assign acc_sum = r_acc + wsp_pkg::fx_round(r_prod);
    assign sum_ok  = wsp_pkg::in_range(acc_sum);
    assign sc_val  = r_prod >>> 1;

    // divider operands
    always_comb begin
        case (r_dsel)
            2'd0:    begin dv_num = r_clip_x; dv_den = r_clip_w; end
            2'd1:    begin dv_num = r_clip_y; dv_den = r_clip_w; end
            2'd2:    begin dv_num = r_nx;     dv_den = r_ww;     end
            default: begin dv_num = r_ny;     dv_den = r_ww;     end
        endcase
    end

    assign num_mag  = dv_num[CW-1] ? -{dv_num[CW-1], dv_num} : {dv_num[CW-1], dv_num};
    assign den_mag  = dv_den[CW-1] ? -{dv_den[CW-1], dv_den} : {dv_den[CW-1], dv_den};
    assign trial    = {r_rem, r_dd[DW-1]};
    assign trial_ge = (trial >= {1'b0, r_den});
    assign dv_fit   = (r_dd[DW-1:CW] == '0)
                   && (!r_dd[CW-1] || (r_neg && (r_dd[CW-2:0] == '0)));
    assign dv_q     = r_neg ? -$signed(r_dd[CW-1:0]) : $signed(r_dd[CW-1:0]);

    // matrix memories
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.opcode == wsp_pkg::OP_LOAD_VIEW) begin
            r_view_mem[i_in_data.elem_index] <= i_in_data.elem_value;
        end
        if (in_acc && i_in_data.opcode == wsp_pkg::OP_LOAD_PROJ) begin
            r_proj_mem[i_in_data.elem_index] <= i_in_data.elem_value;
        end
        if (r_state == S_VP_RD) begin
            r_view_q <= r_view_mem[{r_i[3:2], r_k}];
            r_proj_q <= r_proj_mem[{r_k, r_i[1:0]}];
        end
    end

    // sequencer, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= wsp_pkg::WIDTH_RST;
            r_height    <= wsp_pkg::HEIGHT_RST;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == wsp_pkg::CFG_IDX_WIDTH) begin
                    r_width <= pwdata[wsp_pkg::CFG_WIDTH-1:0];
                end else begin
                    r_height <= pwdata[wsp_pkg::CFG_WIDTH-1:0];
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_data.opcode == wsp_pkg::OP_XFORM) begin
                        r_pt[0] <= i_in_data.world_x;
                        r_pt[1] <= i_in_data.world_y;
                        r_pt[2] <= i_in_data.world_z;
                        r_pt[3] <= '0;
                        r_ww    <= i_in_data.world_w;
                        r_i     <= '0;
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_ok    <= 1'b1;
                        r_state <= S_VP_RD;
                    end
                end
                S_VP_RD: r_state <= S_VP_MUL;
                S_VP_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_VP_ACC;
                end
                S_VP_ACC: begin
                    r_state <= S_VP_RD;
                    r_k     <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_vp[r_i] <= acc_sum[CW-1:0];
                        r_acc     <= '0;
                        r_i       <= r_i + 4'd1;
                        if (!sum_ok) begin
                            r_ok <= 1'b0;
                        end
                        if (r_i == 4'd15) begin
                            // any VP element out of range ends here
                            r_col   <= 2'd0;
                            r_state <= (r_ok && sum_ok) ? S_CL_MUL : S_OUT;
                        end
                    end else begin
                        r_acc <= acc_sum;
                    end
                end
                S_CL_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_CL_ACC;
                end
                S_CL_ACC: begin
                    r_state <= S_CL_MUL;
                    r_k     <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_acc <= '0;
                        if (!sum_ok) begin
                            r_ok    <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            case (r_col)
                                2'd0: begin
                                    r_clip_x <= acc_sum[CW-1:0];
                                    r_col    <= 2'd1;
                                end
                                2'd1: begin
                                    r_clip_y <= acc_sum[CW-1:0];
                                    r_col    <= 2'd3;
                                end
                                default: begin
                                    r_clip_w <= acc_sum[CW-1:0];
                                    r_dsel   <= 2'd0;
                                    if (acc_sum[CW-1:0] == '0 || r_ww == '0) begin
                                        r_ok    <= 1'b0;
                                        r_state <= S_OUT;
                                    end else begin
                                        r_state <= S_DV_INIT;
                                    end
                                end
                            endcase
                        end
                    end else begin
                        r_acc <= acc_sum;
                    end
                end
                S_DV_INIT: begin
                    r_dd    <= {num_mag[CW-1:0], {wsp_pkg::FRAC_BITS{1'b0}}};
                    r_den   <= den_mag[CW-1:0];
                    r_rem   <= '0;
                    r_neg   <= dv_num[CW-1] ^ dv_den[CW-1];
                    r_cnt   <= '0;
                    r_state <= S_DV_RUN;
                end
                S_DV_RUN: begin
                    // one quotient bit per cycle, restoring
                    if (trial_ge) begin
                        r_rem <= CW'(trial - {1'b0, r_den});
                    end else begin
                        r_rem <= trial[CW-1:0];
                    end
                    r_dd  <= {r_dd[DW-2:0], trial_ge};
                    r_cnt <= r_cnt + CNW'(1);
                    if (r_cnt == CNW'(DW - 1)) begin
                        r_state <= S_DV_DONE;
                    end
                end
                S_DV_DONE: begin
                    case (r_dsel)
                        2'd0:    r_nx <= dv_q;
                        2'd1:    r_ny <= dv_q;
                        2'd2:    r_wx <= dv_q;
                        default: r_wy <= dv_q;
                    endcase
                    r_dsel <= r_dsel + 2'd1;
                    r_sc   <= 1'b0;
                    if (!dv_fit) begin
                        r_ok    <= 1'b0;
                        r_state <= S_OUT;
                    end else if (r_dsel == 2'd3) begin
                        r_state <= S_SC_MUL;
                    end else begin
                        r_state <= S_DV_INIT;
                    end
                end
                S_SC_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SC_CHK;
                end
                S_SC_CHK: begin
                    if (r_sc) begin
                        r_sy <= sc_val[CW-1:0];
                    end else begin
                        r_sx <= sc_val[CW-1:0];
                    end
                    r_sc <= 1'b1;
                    if (!wsp_pkg::in_range(sc_val)) begin
                        r_ok    <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= r_sc ? S_OUT : S_SC_MUL;
                    end
                end
                S_OUT: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid         <= 1'b1;
                        r_out_data.screen_x <= r_ok ? r_sx : '0;
                        r_out_data.screen_y <= r_ok ? r_sy : '0;
                        r_out_data.invalid  <= !r_ok;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `CHK_SAME(a_invalid_zero, o_out_valid && o_out_data.invalid, (o_out_data.screen_x == '0) && (o_out_data.screen_y == '0), "invalid result with nonzero coordinates")
    `CHK_NEXT(a_busy_after_xform, i_in_valid && o_in_ready && (i_in_data.opcode == wsp_pkg::OP_XFORM), !o_in_ready, "ready right after a transform transfer")
    `CHK_SAME(a_div_count, r_state == S_DV_RUN, r_cnt < CNW'(DW), "divider step count out of bounds")

endmodule

@@ test/tb_top.sv @@
// Testbench of the world-to-screen projection block: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

// Holds a private copy of both matrices and the viewport registers, works out the
// screen point of every accepted transform and keeps it until the block posts one.
class projection_scoreboard;
    longint      view_m[16];
    longint      proj_m[16];
    longint      scr_w;
    longint      scr_h;
    wsp_pkg::t_out_item pending_pts[$];
    int          errors;

    function new();
        foreach (view_m[i]) begin
            view_m[i] = 0;
            proj_m[i] = 0;
        end
        scr_w  = 1280;
        scr_h  = 720;
        errors = 0;
    endfunction

    function void set_reg(logic [wsp_pkg::ADDR_WIDTH-1:0] addr, logic [31:0] data);
        // register i sits at byte address 4*i; only bits 13:0 are kept
        if (addr[2] == wsp_pkg::CFG_IDX_WIDTH)
            scr_w = longint'(data[wsp_pkg::CFG_WIDTH-1:0]);
        else
            scr_h = longint'(data[wsp_pkg::CFG_WIDTH-1:0]);
    endfunction

    function bit fits(longint v);
        return (v >= -64'sd2147483648) && (v <= 64'sd2147483647);
    endfunction

    // rounded fixed-point product: floor((a*b + half) / 2^F)
    function longint fx_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< (wsp_pkg::FRAC_BITS - 1))) >>> wsp_pkg::FRAC_BITS;
    endfunction

    // quotient truncated toward zero; den is nonzero
    function bit fx_quot(longint num, longint den, output longint q);
        q = (num * (64'sd1 <<< wsp_pkg::FRAC_BITS)) / den;
        return fits(q);
    endfunction

    function void note_input(wsp_pkg::t_in_item it);
        longint    vp[16];
        longint    pt[3];
        longint    clip[3];
        longint    ww, acc, nx, ny, wx, wy, one;
        int        cols[3];
        bit        ok;
        wsp_pkg::t_out_item res;
        one = 64'sd1 <<< wsp_pkg::FRAC_BITS;
        case (it.opcode)
            wsp_pkg::OP_LOAD_VIEW: begin
                view_m[it.elem_index] = longint'(it.elem_value);
            end
            wsp_pkg::OP_LOAD_PROJ: begin
                proj_m[it.elem_index] = longint'(it.elem_value);
            end
            wsp_pkg::OP_XFORM: begin
                ok    = 1'b1;
                pt[0] = longint'(it.world_x);
                pt[1] = longint'(it.world_y);
                pt[2] = longint'(it.world_z);
                ww    = longint'(it.world_w);
                for (int r = 0; r < 4; r++) begin
                    for (int c = 0; c < 4; c++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += fx_mul(view_m[r*4+k], proj_m[k*4+c]);
                        if (!fits(acc))
                            ok = 1'b0;
                        vp[r*4+c] = acc;
                    end
                end
                res = '0;
                if (ok) begin
                    // clip x, y, w: columns 0, 1 and 3, the z column is unused
                    cols = '{0, 1, 3};
                    for (int c = 0; c < 3; c++) begin
                        acc = vp[12 + cols[c]];
                        for (int k = 0; k < 3; k++)
                            acc += fx_mul(pt[k], vp[k*4 + cols[c]]);
                        if (!fits(acc))
                            ok = 1'b0;
                        clip[c] = acc;
                    end
                    if (ok && (clip[2] == 0 || ww == 0))
                        ok = 1'b0;
                    if (ok)
                        ok = fx_quot(clip[0], clip[2], nx) && fx_quot(clip[1], clip[2], ny);
                    if (ok)
                        ok = fx_quot(nx, ww, wx) && fx_quot(ny, ww, wy);
                    if (ok) begin
                        wx = ((wx + one) * scr_w) >>> 1;
                        wy = ((one - wy) * scr_h) >>> 1;
                        if (!fits(wx) || !fits(wy))
                            ok = 1'b0;
                    end
                    if (ok) begin
                        res.screen_x = wx[31:0];
                        res.screen_y = wy[31:0];
                    end
                end
                res.invalid = !ok;
                pending_pts.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function void check_result(wsp_pkg::t_out_item got);
        wsp_pkg::t_out_item exp_pt;
        if (pending_pts.size() == 0) begin
            $display("%0t: unexpected result x=%0d y=%0d invalid=%0b", $time,
                     got.screen_x, got.screen_y, got.invalid);
            errors++;
            return;
        end
        exp_pt = pending_pts.pop_front();
        if (got.screen_x !== exp_pt.screen_x) begin
            $display("%0t: screen_x expected %0d got %0d", $time, exp_pt.screen_x, got.screen_x);
            errors++;
        end
        if (got.screen_y !== exp_pt.screen_y) begin
            $display("%0t: screen_y expected %0d got %0d", $time, exp_pt.screen_y, got.screen_y);
            errors++;
        end
        if (got.invalid !== exp_pt.invalid) begin
            $display("%0t: invalid expected %0b got %0b", $time, exp_pt.invalid, got.invalid);
            errors++;
        end
    endfunction
endclass

module tb_top;
    // margin after each drain, long enough to cover the tail of any transform
    localparam int DRAIN_CYCLES = 600;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int ONE          = 65536;
    // opcode with no function in the block
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // register byte addresses
    localparam logic [wsp_pkg::ADDR_WIDTH-1:0] REG_WIDTH  = 3'd0;
    localparam logic [wsp_pkg::ADDR_WIDTH-1:0] REG_HEIGHT = 3'd4;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    wsp_pkg::t_in_item       i_in_data;
    logic                    o_out_valid;
    logic                    i_out_ready;
    wsp_pkg::t_out_item      o_out_data;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [wsp_pkg::ADDR_WIDTH-1:0] paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    projection_scoreboard    sb;
    int                      tx_idle_pct;
    int                      rx_idle_pct;
    int                      cycles = 0;

    world_to_screen_projection uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // watchdog: a stuck handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // every result transfer is checked against the oldest predicted point
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_data);
    end

    // register write: setup cycle, then access cycle; pready is always high
    task automatic apb_write(input logic [wsp_pkg::ADDR_WIDTH-1:0] addr,
                             input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.set_reg(addr, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // one input transfer; valid stays high between back-to-back items
    task automatic send_item(input wsp_pkg::t_in_item it);
        int gap;
        gap = 0;
        while (gap < 60 && $urandom_range(99) < tx_idle_pct)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = it;
        i_in_valid = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic send_op(input logic [1:0] op, input int idx, input int val,
                           input int x, input int y, input int z, input int w);
        wsp_pkg::t_in_item it;
        it.opcode     = op;
        it.elem_index = idx[3:0];
        it.elem_value = val;
        it.world_x    = x;
        it.world_y    = y;
        it.world_z    = z;
        it.world_w    = w;
        send_item(it);
    endtask

    // drop valid and wait for every predicted point to come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_pts.size() != 0)
            @(posedge i_clk);
    endtask

    // a camera-like setup: identity view, projection with w taken from z
    task automatic load_base_matrices();
        for (int i = 0; i < 16; i++)
            send_op(wsp_pkg::OP_LOAD_VIEW, i, (i % 5 == 0) ? ONE : 0,
                    $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < 16; i++) begin
            int v;
            case (i)
                0:       v = ONE + ONE / 2;
                5:       v = 2 * ONE;
                10:      v = ONE;
                11:      v = ONE;
                14:      v = -ONE / 4;
                default: v = 0;
            endcase
            send_op(wsp_pkg::OP_LOAD_PROJ, i, v, 0, 0, 0, 0);
        end
    endtask

    function automatic int small_coord(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic random_item();
        int sel;
        int x, y, z, w;
        sel = $urandom_range(99);
        if (sel < 2) begin
            // opcode 3 is dropped by the block
            send_op(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (sel < 12) begin
            // element reload; rarely a full-range value that will overflow VP
            send_op($urandom_range(1) ? wsp_pkg::OP_LOAD_PROJ : wsp_pkg::OP_LOAD_VIEW,
                    $urandom_range(15),
                    ($urandom_range(99) < 8) ? int'($urandom) : small_coord(2 * ONE),
                    $urandom, $urandom, $urandom, $urandom);
        end else begin
            x = small_coord(4 * ONE);
            y = small_coord(4 * ONE);
            z = int'($urandom_range(ONE / 4, 12 * ONE));
            if ($urandom_range(3) == 0)
                z = -z;
            w = int'($urandom_range(ONE / 2, 3 * ONE));
            if ($urandom_range(1))
                w = -w;
            if ($urandom_range(19) == 0) x = $urandom;
            if ($urandom_range(19) == 0) y = $urandom;
            if ($urandom_range(19) == 0) z = $urandom;
            if ($urandom_range(19) == 0) w = $urandom;
            if ($urandom_range(49) == 0) w = 0;
            send_op(wsp_pkg::OP_XFORM, $urandom, $urandom, x, y, z, w);
        end
    endtask

    initial begin
        int widths[6];
        int heights[6];

        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        tx_idle_pct = 16;
        rx_idle_pct = 85;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        apb_write(REG_WIDTH, 32'd1280);
        apb_write(REG_HEIGHT, 32'd720);

        // directed: full matrix load first so no unwritten entry is ever read
        load_base_matrices();
        send_op(wsp_pkg::OP_XFORM, 15, -1, ONE, ONE / 2, 4 * ONE, ONE);
        send_op(wsp_pkg::OP_XFORM, 0, 0, 0, 0, 0, ONE);                  // clip w of zero
        send_op(wsp_pkg::OP_XFORM, 0, 0, ONE, ONE, 2 * ONE, 0);          // point w of zero
        send_op(wsp_pkg::OP_XFORM, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff);
        send_op(wsp_pkg::OP_XFORM, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000);
        send_op(wsp_pkg::OP_XFORM, 0, 0, -ONE, -ONE, -3 * ONE, -ONE / 2);
        send_op(wsp_pkg::OP_XFORM, 0, 0, ONE / 64, -ONE / 64, ONE / 1024, 1); // tiny divisors
        send_op(OP_UNUSED, 15, 32'h7fffffff, ONE, ONE, ONE, ONE);    // ignored opcode
        send_op(wsp_pkg::OP_XFORM, 0, 0, 2 * ONE, -ONE, 5 * ONE, 2 * ONE);
        // extreme elements force a VP overflow, then the base values come back
        send_op(wsp_pkg::OP_LOAD_VIEW, 0, 32'h7fffffff, 0, 0, 0, 0);
        send_op(wsp_pkg::OP_LOAD_PROJ, 0, 32'h80000000, 0, 0, 0, 0);
        send_op(wsp_pkg::OP_XFORM, 0, 0, ONE, ONE, 2 * ONE, ONE);
        send_op(wsp_pkg::OP_LOAD_VIEW, 0, ONE, 0, 0, 0, 0);
        send_op(wsp_pkg::OP_LOAD_PROJ, 0, ONE + ONE / 2, 0, 0, 0, 0);

        // viewport settings per phase, extremes and out-of-range values included
        widths  = '{1280, 1, 8192, 0, 16383, 640};
        heights = '{720, 8192, 1, 16383, 0, 480};

        for (int ph = 0; ph < 6; ph++) begin
            drain_results();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            if (ph == 4)
                apb_write(REG_WIDTH, 32'hffff_c000 | widths[ph]);  // upper bits dropped
            else
                apb_write(REG_WIDTH, widths[ph]);
            apb_write(REG_HEIGHT, heights[ph]);
            if (ph < 2) begin
                tx_idle_pct = 16;
                rx_idle_pct = 85;
            end else if (ph < 4) begin
                tx_idle_pct = 85;
                rx_idle_pct = 16;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (ph == 3)
                load_base_matrices();
            for (int n = 0; n < 95; n++) begin
                // sender holds off until all points are back
                if (ph == 2 && n == 40)
                    drain_results();
                random_item();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+src
src/wsp_pkg.sv
src/world_to_screen_projection.sv
test/tb_top.sv
